>>> sv/blsw_pkg.sv
// blinds stepper wave drive package: register map, reset values, drive constants
// and the coil and threshold helpers used by the top level
// no dependencies
package blsw_pkg;

  localparam int unsigned MinuteW = 11;
  localparam int unsigned IntervalW = 6;
  localparam int unsigned StepW = 10;
  localparam int unsigned TimerW = 8;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned CoilW = 4;
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    REG_DAWN          = 3'd0,
    REG_BEFORE_MIDN   = 3'd1,
    REG_AFTER_MIDN    = 3'd2,
    REG_PHASE_IVAL    = 3'd3,
    REG_STEPS_PER_MV  = 3'd4
  } reg_idx_t;

  localparam logic [MinuteW-1:0]   DawnReset        = 11'd360;
  localparam logic [MinuteW-1:0]   BeforeMidnReset  = 11'd1439;
  localparam logic [MinuteW-1:0]   AfterMidnReset   = 11'd0;
  localparam logic [IntervalW-1:0] PhaseIvalReset   = 6'd2;
  localparam logic [StepW-1:0]     StepsPerMvReset  = 10'd512;

  localparam logic [TimerW-1:0] TimerMax   = 8'd255;
  localparam logic [PhaseW-1:0] PhasesAll  = 3'd4;
  localparam logic [PhaseW-1:0] StepEndMul = 3'd5;

  // index into the per-direction state
  localparam logic DirLower = 1'b0;
  localparam logic DirRaise = 1'b1;

  // k * interval, clipped to the timer ceiling
  function automatic logic [TimerW-1:0] threshold(input logic [PhaseW-1:0] k,
                                                  input logic [IntervalW-1:0] ival);
    logic [PhaseW+IntervalW-1:0] prod;
    prod = (PhaseW+IntervalW)'(k) * (PhaseW+IntervalW)'(ival);
    if (prod > (PhaseW+IntervalW)'(TimerMax)) begin
      return TimerMax;
    end
    return prod[TimerW-1:0];
  endfunction

  // lowering walks coil one to four, raising walks four to one
  function automatic logic [CoilW-1:0] coil_for(input logic dir, input logic [1:0] ph);
    if (dir == DirLower) begin
      return 4'b0001 << ph;
    end
    return 4'b1000 >> ph;
  endfunction

endpackage

>>> sv/blinds_stepper_wave_drive.sv
// blinds stepper wave drive top level: tick input register, position and
// per-direction step state, result register and apb register file
// depends on blsw_pkg
//
// Each accepted request is one millisecond tick and yields exactly one result.
// A tick is held in the input register, where it is evaluated against the
// position, direction timers, phase and step counters, and coil latch; the state
// and the result register update together as it moves on. One request is taken
// per clock cycle as long as the result side keeps up. The user must write the
// registers through the apb port only while no tick is in flight; the block does
// not enforce this. pready is tied high and reads return the register value.
module blinds_stepper_wave_drive
  import blsw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_automatic_on,
  input  logic [MinuteW-1:0] in_time_of_day,
  input  logic [MinuteW-1:0] in_dusk_minute,
  input  logic               in_raise_switch,
  input  logic               in_lower_switch,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CoilW-1:0]   out_coil_pattern,
  output logic               out_blinds_lowered,
  output logic               out_move_done,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready
);

  // configuration registers
  logic [MinuteW-1:0]   dawn_r, before_midn_r, after_midn_r;
  logic [IntervalW-1:0] phase_ival_r;
  logic [StepW-1:0]     steps_per_mv_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dawn_r         <= DawnReset;
      before_midn_r  <= BeforeMidnReset;
      after_midn_r   <= AfterMidnReset;
      phase_ival_r   <= PhaseIvalReset;
      steps_per_mv_r <= StepsPerMvReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DAWN:         dawn_r         <= pwdata[MinuteW-1:0];
        REG_BEFORE_MIDN:  before_midn_r  <= pwdata[MinuteW-1:0];
        REG_AFTER_MIDN:   after_midn_r   <= pwdata[MinuteW-1:0];
        REG_PHASE_IVAL:   phase_ival_r   <= pwdata[IntervalW-1:0];
        REG_STEPS_PER_MV: steps_per_mv_r <= pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_DAWN:         prdata = DataW'(dawn_r);
      REG_BEFORE_MIDN:  prdata = DataW'(before_midn_r);
      REG_AFTER_MIDN:   prdata = DataW'(after_midn_r);
      REG_PHASE_IVAL:   prdata = DataW'(phase_ival_r);
      REG_STEPS_PER_MV: prdata = DataW'(steps_per_mv_r);
      default:          prdata = '0;
    endcase
  end

  // input register and handshake
  logic               s1_valid_r;
  logic               s1_auto_r, s1_raise_sw_r, s1_lower_sw_r;
  logic [MinuteW-1:0] s1_time_r, s1_dusk_r;
  logic               advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_auto_r     <= in_automatic_on;
      s1_time_r     <= in_time_of_day;
      s1_dusk_r     <= in_dusk_minute;
      s1_raise_sw_r <= in_raise_switch;
      s1_lower_sw_r <= in_lower_switch;
    end
  end

  // drive state
  logic              pos_lowered_r, pos_lowered_nxt;
  logic [TimerW-1:0] timer_r [2];
  logic [TimerW-1:0] timer_nxt [2];
  logic [TimerW-1:0] timer_inc [2];
  logic [PhaseW-1:0] phase_r [2];
  logic [PhaseW-1:0] phase_nxt [2];
  logic [StepW-1:0]  count_r [2];
  logic [StepW-1:0]  count_nxt [2];
  logic [CoilW-1:0]  coil_r, coil_nxt;
  logic              done_nxt;

  logic              night, day;
  logic              drive_en, dir;
  logic [PhaseW-1:0] ph_sel;
  logic              fire;

  assign fire = s1_valid_r && advance;

  always_comb begin
    night = (s1_time_r >= s1_dusk_r && s1_time_r <= before_midn_r) ||
            (s1_time_r >= after_midn_r && s1_time_r <= dawn_r);
    day   = s1_time_r >= dawn_r && s1_time_r <= s1_dusk_r;

    drive_en = 1'b0;
    dir      = DirLower;
    if (s1_auto_r) begin
      if (night && !pos_lowered_r) begin
        drive_en = 1'b1;
        dir      = DirLower;
      end else if (day && pos_lowered_r) begin
        drive_en = 1'b1;
        dir      = DirRaise;
      end
    end else begin
      // raise switch is checked first
      if (s1_raise_sw_r && pos_lowered_r) begin
        drive_en = 1'b1;
        dir      = DirRaise;
      end else if (s1_lower_sw_r && !pos_lowered_r) begin
        drive_en = 1'b1;
        dir      = DirLower;
      end
    end
  end

  always_comb begin
    for (int d = 0; d < 2; d++) begin
      timer_inc[d] = (timer_r[d] == TimerMax) ? timer_r[d] : timer_r[d] + 1'b1;
      timer_nxt[d] = timer_inc[d];
      phase_nxt[d] = phase_r[d];
      count_nxt[d] = count_r[d];
    end
    coil_nxt        = coil_r;
    pos_lowered_nxt = pos_lowered_r;
    done_nxt        = 1'b0;

    // phase counter above four counts as all phases done
    ph_sel = (phase_r[dir] > PhasesAll) ? PhasesAll : phase_r[dir];

    if (drive_en) begin
      if (count_r[dir] >= steps_per_mv_r) begin
        count_nxt[dir]  = '0;
        done_nxt        = 1'b1;
        pos_lowered_nxt = (dir == DirLower);
      end else if (ph_sel < PhasesAll) begin
        if (timer_inc[dir] >= threshold(ph_sel + 1'b1, phase_ival_r)) begin
          coil_nxt       = coil_for(dir, ph_sel[1:0]);
          phase_nxt[dir] = ph_sel + 1'b1;
        end
      end else if (timer_inc[dir] >= threshold(StepEndMul, phase_ival_r)) begin
        timer_nxt[dir] = '0;
        phase_nxt[dir] = '0;
        count_nxt[dir] = count_r[dir] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_lowered_r <= 1'b0;
      coil_r        <= '0;
      for (int d = 0; d < 2; d++) begin
        timer_r[d] <= '0;
        phase_r[d] <= '0;
        count_r[d] <= '0;
      end
    end else if (fire) begin
      pos_lowered_r <= pos_lowered_nxt;
      coil_r        <= coil_nxt;
      for (int d = 0; d < 2; d++) begin
        timer_r[d] <= timer_nxt[d];
        phase_r[d] <= phase_nxt[d];
        count_r[d] <= count_nxt[d];
      end
    end
  end

  // result register
  logic             out_valid_r;
  logic [CoilW-1:0] out_coil_r;
  logic             out_lowered_r, out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_coil_r    <= coil_nxt;
      out_lowered_r <= pos_lowered_nxt;
      out_done_r    <= done_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_coil_pattern   = out_coil_r;
  assign out_blinds_lowered = out_lowered_r;
  assign out_move_done      = out_done_r;

endmodule

>>> dv/tb_blinds_stepper_wave_drive.sv
// testbench for blinds_stepper_wave_drive: directed corners, random tick runs under
// several register settings, idling on both sides and a long result-side hold-off
// depends on blsw_pkg and the blinds_stepper_wave_drive top level
module tb_blinds_stepper_wave_drive;
  timeunit 1ns;
  timeprecision 1ps;
  import blsw_pkg::*;

  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    logic [CoilW-1:0] coil;
    logic             lowered;
    logic             done;
  } drive_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_automatic_on;
  logic [MinuteW-1:0] in_time_of_day;
  logic [MinuteW-1:0] in_dusk_minute;
  logic               in_raise_switch;
  logic               in_lower_switch;
  logic               out_valid;
  logic               out_ready;
  logic [CoilW-1:0]   out_coil_pattern;
  logic               out_blinds_lowered;
  logic               out_move_done;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [DataW-1:0]   pwdata;
  logic [DataW-1:0]   prdata;
  logic               pready;

  blinds_stepper_wave_drive DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_automatic_on    (in_automatic_on),
    .in_time_of_day     (in_time_of_day),
    .in_dusk_minute     (in_dusk_minute),
    .in_raise_switch    (in_raise_switch),
    .in_lower_switch    (in_lower_switch),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_coil_pattern   (out_coil_pattern),
    .out_blinds_lowered (out_blinds_lowered),
    .out_move_done      (out_move_done),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // predictor copy of the registers
  logic [MinuteW-1:0]   dawn_q;
  logic [MinuteW-1:0]   eve_end_q;
  logic [MinuteW-1:0]   morn_start_q;
  logic [IntervalW-1:0] ival_q;
  logic [StepW-1:0]     steps_q;

  // predictor copy of the position and per-direction stepping state
  logic              pos_lowered;
  logic [TimerW-1:0] dir_timer [2];
  logic [PhaseW-1:0] dir_phase [2];
  logic [StepW-1:0]  dir_steps [2];
  logic [CoilW-1:0]  coil_q;

  drive_result_t coil_results_q[$];
  drive_result_t exp_r;
  int            errors;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            hold_req;
  int            hold_cnt;
  int            stall_cnt;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [TimerW-1:0] phase_limit(input int unsigned k);
    int unsigned prod;
    prod = k * ival_q;
    if (prod > TimerMax) begin
      return TimerMax;
    end
    return prod[TimerW-1:0];
  endfunction

  // one driven tick of a direction, returns 1 when the move completes
  function automatic logic step_direction(input logic dir);
    logic [PhaseW-1:0] ph;
    ph = dir_phase[dir];
    if (ph > PhasesAll) begin
      ph = PhasesAll;
    end
    if (dir_steps[dir] >= steps_q) begin
      dir_steps[dir] = '0;
      return 1'b1;
    end
    if (ph < PhasesAll) begin
      if (dir_timer[dir] >= phase_limit(ph + 1)) begin
        coil_q = (dir == DirLower) ? (4'b0001 << ph) : (4'b1000 >> ph);
        dir_phase[dir] = ph + 1'b1;
      end
    end else if (dir_timer[dir] >= phase_limit(32'(StepEndMul))) begin
      dir_timer[dir] = '0;
      dir_phase[dir] = '0;
      dir_steps[dir] = dir_steps[dir] + 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic drive_result_t predict_tick(input logic auto_on,
                                                 input logic [MinuteW-1:0] tod,
                                                 input logic [MinuteW-1:0] dusk,
                                                 input logic rs, input logic ls);
    drive_result_t r;
    logic night;
    logic day;
    logic done;
    done = 1'b0;
    for (int d = 0; d < 2; d++) begin
      if (dir_timer[d] != TimerMax) begin
        dir_timer[d] = dir_timer[d] + 1'b1;
      end
    end
    if (auto_on) begin
      night = (tod >= dusk && tod <= eve_end_q) || (tod >= morn_start_q && tod <= dawn_q);
      day = tod >= dawn_q && tod <= dusk;
      if (night && !pos_lowered) begin
        if (step_direction(DirLower)) begin
          pos_lowered = 1'b1;
          done = 1'b1;
        end
      end else if (day && pos_lowered) begin
        if (step_direction(DirRaise)) begin
          pos_lowered = 1'b0;
          done = 1'b1;
        end
      end
    end else begin
      if (rs && pos_lowered) begin
        if (step_direction(DirRaise)) begin
          pos_lowered = 1'b0;
          done = 1'b1;
        end
      end else if (ls && !pos_lowered) begin
        if (step_direction(DirLower)) begin
          pos_lowered = 1'b1;
          done = 1'b1;
        end
      end
    end
    r.coil = coil_q;
    r.lowered = pos_lowered;
    r.done = done;
    return r;
  endfunction

  task automatic reset_predictor();
    dawn_q = DawnReset;
    eve_end_q = BeforeMidnReset;
    morn_start_q = AfterMidnReset;
    ival_q = PhaseIvalReset;
    steps_q = StepsPerMvReset;
    pos_lowered = 1'b0;
    coil_q = '0;
    for (int d = 0; d < 2; d++) begin
      dir_timer[d] = '0;
      dir_phase[d] = '0;
      dir_steps[d] = '0;
    end
  endtask

  // request tracking and result checking
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        coil_results_q.push_back(predict_tick(in_automatic_on, in_time_of_day,
                                              in_dusk_minute, in_raise_switch,
                                              in_lower_switch));
      end
      if (out_valid && out_ready) begin
        if (coil_results_q.size() == 0) begin
          $display("%0t: unexpected result coil %h lowered %b done %b", $time,
                   out_coil_pattern, out_blinds_lowered, out_move_done);
          errors++;
        end else begin
          exp_r = coil_results_q.pop_front();
          if (out_coil_pattern !== exp_r.coil) begin
            $display("%0t: coil_pattern expected %h actual %h", $time, exp_r.coil,
                     out_coil_pattern);
            errors++;
          end
          if (out_blinds_lowered !== exp_r.lowered) begin
            $display("%0t: blinds_lowered expected %b actual %b", $time, exp_r.lowered,
                     out_blinds_lowered);
            errors++;
          end
          if (out_move_done !== exp_r.done) begin
            $display("%0t: move_done expected %b actual %b", $time, exp_r.done,
                     out_move_done);
            errors++;
          end
        end
      end
    end
  end

  // result side: random stalls, or a long hold-off counted here
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
    end
    if (stall_cnt >= StallLimit) begin
      $display("blinds_stepper_wave_drive regression: fail");
      $finish;
    end
  end

  task automatic send_tick(input logic auto_on, input logic [MinuteW-1:0] tod,
                           input logic [MinuteW-1:0] dusk, input logic rs,
                           input logic ls);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_automatic_on <= auto_on;
    in_time_of_day <= tod;
    in_dusk_minute <= dusk;
    in_raise_switch <= rs;
    in_lower_switch <= ls;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // drain all results, then let the pipe settle
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (coil_results_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [DataW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DAWN:         dawn_q = val[MinuteW-1:0];
      REG_BEFORE_MIDN:  eve_end_q = val[MinuteW-1:0];
      REG_AFTER_MIDN:   morn_start_q = val[MinuteW-1:0];
      REG_PHASE_IVAL:   ival_q = val[IntervalW-1:0];
      REG_STEPS_PER_MV: steps_q = val[StepW-1:0];
      default: ;
    endcase
    // idle cycle so back-to-back writes start on a fresh edge
    @(posedge clk);
  endtask

  // upper bits carry junk, the block keeps only the register width
  task automatic apply_settings(input int dawn, input int eve_end, input int morn_start,
                                input int ival, input int steps);
    settle_idle();
    cfg_write(REG_DAWN, (32'($urandom) & ~32'h7FF) | 32'(dawn));
    cfg_write(REG_BEFORE_MIDN, (32'($urandom) & ~32'h7FF) | 32'(eve_end));
    cfg_write(REG_AFTER_MIDN, (32'($urandom) & ~32'h7FF) | 32'(morn_start));
    cfg_write(REG_PHASE_IVAL, (32'($urandom) & ~32'h3F) | 32'(ival));
    cfg_write(REG_STEPS_PER_MV, (32'($urandom) & ~32'h3FF) | 32'(steps));
  endtask

  // mostly runs that hold a move going, with noise runs in between
  task automatic run_tick_mix(input int n_items);
    int sent;
    int len;
    int kind;
    logic rs;
    logic ls;
    logic [MinuteW-1:0] tod;
    logic [MinuteW-1:0] dusk;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(9);
      len = (kind >= 8) ? $urandom_range(1, 10) : $urandom_range(4, 60);
      rs = pos_lowered;
      ls = !pos_lowered;
      if (kind == 4) begin
        rs = 1'b1;
        ls = 1'b1;
      end
      if (!pos_lowered) begin
        tod = MinuteW'($urandom_range(0, 1439));
        dusk = MinuteW'($urandom_range(0, tod));
      end else begin
        tod = (dawn_q <= 1439) ? MinuteW'($urandom_range(dawn_q, 1439)) : 11'd2047;
        dusk = MinuteW'($urandom_range(tod, 2047));
      end
      for (int i = 0; i < len && sent < n_items; i++) begin
        if (kind <= 4) begin
          send_tick(1'b0, MinuteW'($urandom_range(0, 2047)),
                    MinuteW'($urandom_range(0, 2047)), rs, ls);
        end else if (kind <= 7) begin
          send_tick(1'b1, tod, dusk, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
          send_tick(1'($urandom_range(1)), MinuteW'($urandom_range(0, 2047)),
                    MinuteW'($urandom_range(0, 2047)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        sent++;
      end
    end
  endtask

  task automatic test_directed_corners();
    // reset settings: nothing completes, only the early phases of a move
    send_tick(1'b0, 11'd0, 11'd0, 1'b0, 1'b0);
    send_tick(1'b0, 11'd2047, 11'd2047, 1'b1, 1'b1);
    send_tick(1'b0, 11'd1439, 11'd0, 1'b0, 1'b1);
    send_tick(1'b1, 11'd0, 11'd1439, 1'b0, 1'b0);
    send_tick(1'b1, 11'd1439, 11'd1439, 1'b0, 1'b0);
    send_tick(1'b1, 11'd720, 11'd1000, 1'b0, 1'b0);
    send_tick(1'b1, 11'd2047, 11'd0, 1'b1, 1'b1);
    apply_settings(360, 1439, 0, 1, 1);
    // finish the lowering move, then raise with both switches held
    repeat (7) send_tick(1'b0, 11'd600, 11'd1100, 1'b0, 1'b1);
    repeat (8) send_tick(1'b0, 11'd600, 11'd1100, 1'b1, 1'b1);
    // raise switch while already raised does nothing
    send_tick(1'b0, 11'd600, 11'd1100, 1'b1, 1'b0);
    send_tick(1'b1, 11'd800, 11'd1100, 1'b0, 1'b0);
  endtask

  task automatic test_random_settings();
    for (int i = 0; i < 9; i++) begin
      case (i)
        0: apply_settings(360, 1439, 0, 1, 1);
        1: apply_settings($urandom_range(0, 1439), $urandom_range(0, 1439),
                          $urandom_range(0, 1439), $urandom_range(1, 3),
                          $urandom_range(1, 4));
        2: apply_settings(0, 0, 0, 0, 0);
        3: apply_settings(2047, 2047, 2047, 63, 1);
        4: apply_settings(1439, 0, 1439, 2, 3);
        5: apply_settings($urandom_range(0, 1439), $urandom_range(0, 1439),
                          $urandom_range(0, 1439), 50, 1023);
        6: apply_settings($urandom_range(0, 1439), $urandom_range(0, 1439),
                          $urandom_range(0, 1439), $urandom_range(1, 4),
                          $urandom_range(1, 6));
        7: apply_settings(360, 1200, 100, 1, 2);
        default: apply_settings($urandom_range(0, 2047), $urandom_range(0, 2047),
                                $urandom_range(0, 2047), $urandom_range(0, 63),
                                $urandom_range(0, 8));
      endcase
      if (i < 3) begin
        send_idle_pct = 8;
        recv_stall_pct = 82;
      end else if (i < 6) begin
        send_idle_pct = 82;
        recv_stall_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      run_tick_mix(100);
    end
  endtask

  task automatic test_backpressure_fill();
    apply_settings(360, 1439, 0, 1, 2);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 300;
    run_tick_mix(40);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_automatic_on = 1'b0;
    in_time_of_day = '0;
    in_dusk_minute = '0;
    in_raise_switch = 1'b0;
    in_lower_switch = 1'b0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    hold_cnt = 0;
    stall_cnt = 0;
    reset_predictor();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_random_settings();
    test_backpressure_fill();
    in_valid <= 1'b0;
    while (coil_results_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("blinds_stepper_wave_drive regression: pass");
    end else begin
      $display("blinds_stepper_wave_drive regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/blsw_pkg.sv
sv/blinds_stepper_wave_drive.sv
dv/tb_blinds_stepper_wave_drive.sv
